// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NSPLT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define NSPLT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/nsplt_pkg.sv -----
// ----------------------------------------------------------------------------
// nsplt_pkg
// Types, constants and the exp2 root table for the nearest-star block.
// ----------------------------------------------------------------------------
`default_nettype none

package nsplt_pkg;

  localparam int FIELD_W  = 24;  // width of each position field
  localparam int SLOT_W   = 4;
  localparam int NUM_W    = 5;
  localparam int TEMP_W   = 32;
  localparam int LAW_W    = 16;
  localparam int ESC_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int D2_W     = 50;
  localparam int FRAC_W   = 16;

  localparam logic [D2_W-1:0] D2_MAX = '1;

  localparam int DEF_MAX_STARS = 16;
  localparam int DEF_DIMS      = 3;
  localparam int DEF_POS_BITS  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STARS    = 3'd0,
    CFG_TEMP0        = 3'd1,
    CFG_TEMPLAW      = 3'd2,
    CFG_TEMPMIN      = 3'd3,
    CFG_ENERGY_SCALE = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_NORM,
    ST_LOG,
    ST_MULL,
    ST_NEGY,
    ST_EXP,
    ST_PROD,
    ST_SHIFT,
    ST_ENERGY,
    ST_FIN
  } st_t;

  // classified item as held in the front queue
  typedef struct packed {
    logic               query;
    logic               slot_ok;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] px;
    logic [FIELD_W-1:0] py;
    logic [FIELD_W-1:0] pz;
  } item_t;

  typedef logic [31:0] root_tbl_t [FRAC_W];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q2.30 for k = 1..16, built at elaboration
  function automatic root_tbl_t build_roots();
    root_tbl_t   tbl;
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int k = 0; k < FRAC_W; k++) begin
      root = isqrt64(root << 30);
      tbl[k] = root[31:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

`default_nettype wire

// ----- design/nsplt_front.sv -----
// ----------------------------------------------------------------------------
// nsplt_front
// Accepts items, classifies them (load or query, slot in range) and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nsplt_front import nsplt_pkg::*; #(
  parameter int MAX_STARS = DEF_MAX_STARS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [SLOT_W-1:0]  in_star_slot,
  input  wire logic [FIELD_W-1:0] in_pos_x,
  input  wire logic [FIELD_W-1:0] in_pos_y,
  input  wire logic [FIELD_W-1:0] in_pos_z,
  output logic                    q_valid,
  output item_t                   q_item,
  input  wire logic               q_pop
);

  localparam int QD = 2;

  item_t      q_r [QD];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.query   = in_func;
    cls.slot_ok = (32'(in_star_slot) < MAX_STARS);
    cls.slot    = in_star_slot;
    cls.px      = in_pos_x;
    cls.py      = in_pos_y;
    cls.pz      = in_pos_z;
  end

  assign in_ready = (cnt_r != 2'(QD));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `NSPLT_NXT(a_cnt_step, push && !q_pop, cnt_r == $past(cnt_r) + 2'd1, "queue count slip")

endmodule

`default_nettype wire

// ----- design/nsplt_back.sv -----
// ----------------------------------------------------------------------------
// nsplt_back
// Star table, nearest-star search, log2/exp2 power law and energy scaling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nsplt_back import nsplt_pkg::*; #(
  parameter int MAX_STARS = DEF_MAX_STARS,
  parameter int DIMS      = DEF_DIMS,
  parameter int POS_BITS  = DEF_POS_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  input  wire item_t                   q_item,
  output logic                         q_pop,
  input  wire logic [NUM_W-1:0]        num_stars,
  input  wire logic [TEMP_W-1:0]       temp0,
  input  wire logic signed [LAW_W-1:0] templaw,
  input  wire logic [TEMP_W-1:0]       tempmin,
  input  wire logic [ESC_W-1:0]        energy_scale,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [TEMP_W-1:0]            out_temperature,
  output logic [TEMP_W-1:0]            out_specific_energy,
  output logic [D2_W-1:0]              out_nearest_dist_sq,
  output logic                         out_no_star
);

  localparam int IW  = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
  localparam int NW  = $clog2(MAX_STARS + 1);
  localparam int CW  = POS_BITS;
  localparam int DW  = CW + 1;
  localparam int SQW = 2 * DW;

  // low CW bits of the field, sign-extended
  function automatic logic signed [CW-1:0] to_crd(input logic [FIELD_W-1:0] f);
    logic [63:0] w;
    w = {{(64-FIELD_W){f[FIELD_W-1]}}, f};
    return w[CW-1:0];
  endfunction

  function automatic logic [D2_W-1:0] sq_sat(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [DW-1:0]     d;
    logic [DW-1:0]            m;
    logic [SQW-1:0]           s;
    logic [SQW+D2_W-1:0]      w;
    d = DW'(a) - DW'(b);
    m = d[DW-1] ? DW'(-d) : DW'(d);
    s = SQW'(m) * SQW'(m);
    w = (SQW+D2_W)'(s);
    return (w > (SQW+D2_W)'(D2_MAX)) ? D2_MAX : w[D2_W-1:0];
  endfunction

  // star table
  logic signed [CW-1:0] mem_x [MAX_STARS];
  logic signed [CW-1:0] mem_y [MAX_STARS];
  logic signed [CW-1:0] mem_z [MAX_STARS];
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;

  st_t                  state_r, state_nxt;
  logic [NW-1:0]        idx_r, idx_nxt;
  logic                 rdv_r, rdv_nxt;
  logic                 sqv_r, sqv_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic signed [CW-1:0] rd_x_r, rd_y_r, rd_z_r;
  logic [D2_W-1:0]      sqx_r, sqx_nxt, sqy_r, sqy_nxt, sqz_r, sqz_nxt;
  logic [D2_W-1:0]      best_r, best_nxt;
  logic                 none_r, none_nxt;
  logic [D2_W-1:0]      nx_r, nx_nxt;
  logic [5:0]           e_r, e_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [30:0]          lx_r, lx_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic signed [38:0]   prod_r, prod_nxt;
  logic signed [26:0]   y_r, y_nxt;
  logic [31:0]          m_r, m_nxt;
  logic [63:0]          p_r, p_nxt;
  logic [TEMP_W-1:0]    t_r, t_nxt;
  logic [55:0]          ep_r, ep_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0]    out_temp_r, out_temp_nxt;
  logic [TEMP_W-1:0]    out_en_r, out_en_nxt;
  logic [D2_W-1:0]      out_d2_r, out_d2_nxt;
  logic                 out_none_r, out_none_nxt;

  logic [NW-1:0]        n_lim;
  logic                 issue;
  logic [D2_W+1:0]      dsum;
  logic [D2_W-1:0]      dsat;
  logic [5:0]           nsh;
  logic [61:0]          lsq;
  logic [31:0]          l32;
  logic signed [6:0]    ediff;
  logic signed [22:0]   lval;
  logic [63:0]          mm;
  logic signed [11:0]   sh;
  logic [11:0]          nsh_r;
  logic [95:0]          wide;
  logic [63:0]          rsh;
  logic [TEMP_W-1:0]    tv;
  logic [TEMP_W-1:0]    tsp;
  logic [39:0]          ev;

  assign n_lim = (32'(num_stars) > MAX_STARS) ? NW'(MAX_STARS) : NW'(num_stars);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rdv_nxt       = 1'b0;
    sqv_nxt       = rdv_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    sqx_nxt       = sq_sat(px_r, rd_x_r);
    sqy_nxt       = (DIMS >= 2) ? sq_sat(py_r, rd_y_r) : '0;
    sqz_nxt       = (DIMS >= 3) ? sq_sat(pz_r, rd_z_r) : '0;
    best_nxt      = best_r;
    none_nxt      = none_r;
    nx_nxt        = nx_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    lx_nxt        = lx_r;
    frac_nxt      = frac_r;
    prod_nxt      = prod_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    t_nxt         = t_r;
    ep_nxt        = ep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_temp_nxt  = out_temp_r;
    out_en_nxt    = out_en_r;
    out_d2_nxt    = out_d2_r;
    out_none_nxt  = out_none_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = IW'(q_item.slot);
    issue         = (idx_r != n_lim);

    dsum = (D2_W+2)'(sqx_r) + (D2_W+2)'(sqy_r) + (D2_W+2)'(sqz_r);
    dsat = (dsum > (D2_W+2)'(D2_MAX)) ? D2_MAX : dsum[D2_W-1:0];

    nsh   = 6'd32 >> cnt_r[2:0];
    lsq   = 62'(lx_r) * 62'(lx_r);
    l32   = lsq[61:30];
    ediff = $signed({1'b0, e_r}) - 7'sd24;
    lval  = {ediff, frac_r};
    mm    = 64'(m_r) * 64'(ROOT_TBL[cnt_r]);

    sh    = $signed({y_r[26], y_r[26:16]}) - 12'sd30;
    nsh_r = 12'(-sh);
    wide  = {32'b0, p_r} << sh[4:0];
    rsh   = p_r >> nsh_r[5:0];
    if (p_r == 64'd0) begin
      tv = '0;
    end else if (!sh[11]) begin
      if (sh >= 12'sd32) tv = '1;
      else tv = (wide[95:32] != 64'd0) ? '1 : wide[31:0];
    end else begin
      if (nsh_r >= 12'd64) tv = '0;
      else tv = (rsh[63:32] != 32'd0) ? '1 : rsh[31:0];
    end

    if (templaw > 16'sd0) tsp = '1;
    else if (templaw == 16'sd0) tsp = temp0;
    else tsp = '0;

    ev = ep_r[55:16];

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_item.query) begin
            wr_en = q_item.slot_ok;
          end else begin
            px_nxt   = to_crd(q_item.px);
            py_nxt   = to_crd(q_item.py);
            pz_nxt   = to_crd(q_item.pz);
            best_nxt = D2_MAX;
            idx_nxt  = '0;
            if (n_lim == '0) begin
              none_nxt  = 1'b1;
              best_nxt  = '0;
              t_nxt     = tempmin;
              state_nxt = ST_ENERGY;
            end else begin
              none_nxt  = 1'b0;
              state_nxt = ST_SRCH;
            end
          end
        end
      end
      ST_SRCH: begin
        rdv_nxt = issue;
        idx_nxt = idx_r + NW'(issue);
        if (sqv_r && (dsat < best_r)) best_nxt = dsat;
        if (!issue && !rdv_r && !sqv_r) begin
          if (best_r == '0) begin
            t_nxt     = (tsp < tempmin) ? tempmin : tsp;
            state_nxt = ST_ENERGY;
          end else begin
            nx_nxt    = best_r;
            e_nxt     = 6'(D2_W - 1);
            cnt_nxt   = '0;
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if ((nx_r >> (6'(D2_W) - nsh)) == '0) begin
          nx_nxt = nx_r << nsh;
          e_nxt  = e_r - nsh;
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd5) begin
          cnt_nxt   = '0;
          lx_nxt    = nx_r[D2_W-1:D2_W-31];
          if ((nx_r >> (6'(D2_W) - nsh)) == '0) lx_nxt = nx_nxt[D2_W-1:D2_W-31];
          frac_nxt  = '0;
          state_nxt = ST_LOG;
        end
      end
      ST_LOG: begin
        lx_nxt   = l32[31] ? l32[31:1] : l32[30:0];
        frac_nxt = {frac_r[FRAC_W-2:0], l32[31]};
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = ST_MULL;
      end
      ST_MULL: begin
        prod_nxt  = 39'(templaw) * 39'(lval);
        state_nxt = ST_NEGY;
      end
      ST_NEGY: begin
        // floor(prod / 2^13), negated
        y_nxt     = 27'(-(prod_r >>> 13));
        m_nxt     = 32'd1 << 30;
        cnt_nxt   = '0;
        state_nxt = ST_EXP;
      end
      ST_EXP: begin
        if (y_r[4'd15 - cnt_r]) m_nxt = mm[61:30];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = ST_PROD;
      end
      ST_PROD: begin
        p_nxt     = 64'(temp0) * 64'(m_r);
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        t_nxt     = (tv < tempmin) ? tempmin : tv;
        state_nxt = ST_ENERGY;
      end
      ST_ENERGY: begin
        ep_nxt    = {24'b0, t_r} * {32'b0, energy_scale};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = t_r;
          out_en_nxt    = (ev[39:32] != 8'd0) ? '1 : ev[31:0];
          out_d2_nxt    = best_r;
          out_none_nxt  = none_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= to_crd(q_item.px);
      mem_y[wr_addr] <= to_crd(q_item.py);
      mem_z[wr_addr] <= to_crd(q_item.pz);
    end
    rd_x_r <= mem_x[idx_r[IW-1:0]];
    rd_y_r <= mem_y[idx_r[IW-1:0]];
    rd_z_r <= mem_z[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    sqz_r      <= sqz_nxt;
    best_r     <= best_nxt;
    none_r     <= none_nxt;
    nx_r       <= nx_nxt;
    e_r        <= e_nxt;
    cnt_r      <= cnt_nxt;
    lx_r       <= lx_nxt;
    frac_r     <= frac_nxt;
    prod_r     <= prod_nxt;
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    p_r        <= p_nxt;
    t_r        <= t_nxt;
    ep_r       <= ep_nxt;
    out_temp_r <= out_temp_nxt;
    out_en_r   <= out_en_nxt;
    out_d2_r   <= out_d2_nxt;
    out_none_r <= out_none_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rdv_r       <= 1'b0;
      sqv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rdv_r       <= rdv_nxt;
      sqv_r       <= sqv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature     = out_temp_r;
  assign out_specific_energy = out_en_r;
  assign out_nearest_dist_sq = out_d2_r;
  assign out_no_star         = out_none_r;

  `NSPLT_NXT(a_best_mono, state_r == ST_SRCH, best_r <= $past(best_r), "best grew in search")
  `NSPLT_IMP(a_log_norm, state_r == ST_LOG, lx_r[30], "log mantissa not normalized")
  `NSPLT_IMP(a_none_d2, out_valid_r && out_none_r, out_d2_r == '0, "no-star with distance")

endmodule

`default_nettype wire

// ----- design/nearest_star_power_law_temperature.sv -----
// ----------------------------------------------------------------------------
// nearest_star_power_law_temperature
// Star table plus nearest-star power-law temperature and specific energy.
// ----------------------------------------------------------------------------
// A load item (func 0) stores a star position in slot star_slot (slots at or
// above MAX_STARS are dropped); it gives no result. A query item (func 1)
// searches stars 0..min(num_stars, MAX_STARS)-1 for the smallest squared
// distance, then returns temperature = max(temp0 * d^-templaw, tempmin) and
// specific_energy = temperature * energy_scale. A query steps one star per
// cycle through a registered read / square / compare pipeline; then, unless
// the distance is zero, it runs 6 leading-one normalize steps, 16 squaring
// rounds for log2, 16 root multiplies for exp2, the temp0 product and the
// shift, and ends with the energy multiply. Items are taken into a two-entry
// queue, so the input can run up to two items ahead while the back end works;
// a finished result sits in an output register. With no stars the result is
// tempmin and no_star is set. Configuration writes are always ready and must
// only land while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_star_power_law_temperature import nsplt_pkg::*; #(
  parameter int MAX_STARS = DEF_MAX_STARS,
  parameter int DIMS      = DEF_DIMS,
  parameter int POS_BITS  = DEF_POS_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [SLOT_W-1:0]     in_star_slot,
  input  wire logic [FIELD_W-1:0]    in_pos_x,
  input  wire logic [FIELD_W-1:0]    in_pos_y,
  input  wire logic [FIELD_W-1:0]    in_pos_z,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TEMP_W-1:0]          out_temperature,
  output logic [TEMP_W-1:0]          out_specific_energy,
  output logic [D2_W-1:0]            out_nearest_dist_sq,
  output logic                       out_no_star
);

  // configuration registers
  logic [NUM_W-1:0]        num_stars_r;
  logic [TEMP_W-1:0]       temp0_r;
  logic signed [LAW_W-1:0] templaw_r;
  logic [TEMP_W-1:0]       tempmin_r;
  logic [ESC_W-1:0]        escale_r;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_stars_r <= '0;
      temp0_r     <= 32'd65536;
      templaw_r   <= '0;
      tempmin_r   <= '0;
      escale_r    <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_STARS:    num_stars_r <= cfg_data[NUM_W-1:0];
        CFG_TEMP0:        temp0_r     <= cfg_data[TEMP_W-1:0];
        CFG_TEMPLAW:      templaw_r   <= $signed(cfg_data[LAW_W-1:0]);
        CFG_TEMPMIN:      tempmin_r   <= cfg_data[TEMP_W-1:0];
        CFG_ENERGY_SCALE: escale_r    <= cfg_data[ESC_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: accept, classify, queue
  nsplt_front #(
    .MAX_STARS(MAX_STARS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_star_slot(in_star_slot),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // back: table, search, power law, energy
  nsplt_back #(
    .MAX_STARS(MAX_STARS),
    .DIMS     (DIMS),
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .num_stars          (num_stars_r),
    .temp0              (temp0_r),
    .templaw            (templaw_r),
    .tempmin            (tempmin_r),
    .energy_scale       (escale_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_temperature    (out_temperature),
    .out_specific_energy(out_specific_energy),
    .out_nearest_dist_sq(out_nearest_dist_sq),
    .out_no_star        (out_no_star)
  );

endmodule

`default_nettype wire

// ----- dv/nsplt_checker.sv -----
// ----------------------------------------------------------------------------
// nsplt_checker
// Watches the config, input and result channels of the nearest-star block,
// predicts each query result and compares it field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsplt_checker import nsplt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_func,
  input  logic [SLOT_W-1:0]     in_star_slot,
  input  logic [FIELD_W-1:0]    in_pos_x,
  input  logic [FIELD_W-1:0]    in_pos_y,
  input  logic [FIELD_W-1:0]    in_pos_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [TEMP_W-1:0]     out_temperature,
  input  logic [TEMP_W-1:0]     out_specific_energy,
  input  logic [D2_W-1:0]       out_nearest_dist_sq,
  input  logic                  out_no_star,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic [TEMP_W-1:0] energy;
    logic [D2_W-1:0]   d2;
    logic              none;
  } heat_t;

  localparam logic [63:0] U32_SAT = 64'hFFFF_FFFF;

  heat_t                     heat_q[$];
  logic [NUM_W-1:0]          n_stars;
  logic [TEMP_W-1:0]         t_unit;
  logic signed [LAW_W-1:0]   law;
  logic [TEMP_W-1:0]         t_floor;
  logic [ESC_W-1:0]          e_scale;
  logic signed [FIELD_W-1:0] star_px [16];
  logic signed [FIELD_W-1:0] star_py [16];
  logic signed [FIELD_W-1:0] star_pz [16];
  logic [63:0]               root_q30 [1:16];

  assign pending = heat_q.size();

  // floor square root, one result bit per step
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  initial begin
    logic [63:0] rt;
    rt = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      rt = floor_sqrt(rt << 30);
      root_q30[k] = rt;
    end
  end

  function automatic logic [63:0] sq_diff(input logic signed [FIELD_W-1:0] a,
                                          input logic signed [FIELD_W-1:0] b);
    longint d;
    logic [63:0] s;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    s = d * d;
    return (s > 64'(D2_MAX)) ? 64'(D2_MAX) : s;
  endfunction

  // log2 of a Q26.24 distance, signed Q.16
  function automatic longint log2_fix(input logic [63:0] d2);
    int e;
    logic [63:0] x;
    longint frac;
    e = 63;
    frac = 0;
    while (e > 0 && !d2[e]) e--;
    x = (e <= 30) ? (d2 << (30 - e)) : (d2 >> (e - 30));
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e - 24) * 65536 + frac;
  endfunction

  // temp0 * 2^(y / 65536), saturated to 32 bits
  function automatic logic [63:0] pow2_scaled(input longint y);
    logic [15:0] yf;
    longint s;
    logic [63:0] m;
    logic [63:0] p;
    yf = y[15:0];
    s = (y >>> 16) - 30;
    m = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (yf[16-k]) m = (m * root_q30[k]) >> 30;
    p = 64'(t_unit) * m;
    if (p == 0) return 0;
    if (s >= 0) begin
      if (s >= 32 || p > (U32_SAT >> s)) return U32_SAT;
      return p << s;
    end
    if (-s >= 64) return 0;
    p = p >> (-s);
    return (p > U32_SAT) ? U32_SAT : p;
  endfunction

  function automatic heat_t nearest_heat(input logic signed [FIELD_W-1:0] x,
                                         input logic signed [FIELD_W-1:0] y,
                                         input logic signed [FIELD_W-1:0] z);
    heat_t h;
    int n;
    logic [63:0] best;
    logic [63:0] d;
    logic [63:0] t;
    logic [63:0] en;
    longint prod;
    n = (n_stars > 16) ? 16 : int'(n_stars);
    best = 64'(D2_MAX);
    for (int i = 0; i < n; i++) begin
      d = sq_diff(x, star_px[i]) + sq_diff(y, star_py[i]) + sq_diff(z, star_pz[i]);
      if (d > 64'(D2_MAX)) d = 64'(D2_MAX);
      if (d < best) best = d;
    end
    if (n == 0) begin
      best = 0;
      t = 64'(t_floor);
    end else begin
      if (best == 0) begin
        if (law > 0) t = U32_SAT;
        else if (law == 0) t = 64'(t_unit);
        else t = 0;
      end else begin
        prod = longint'(law) * log2_fix(best);
        t = pow2_scaled(-(prod >>> 13));
      end
      if (t < 64'(t_floor)) t = 64'(t_floor);
    end
    en = (t * 64'(e_scale)) >> 16;
    if (en > U32_SAT) en = U32_SAT;
    h.temp = t[31:0];
    h.energy = en[31:0];
    h.d2 = best[D2_W-1:0];
    h.none = (n == 0);
    return h;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    heat_t w;
    if (!rst_n) begin
      n_stars <= '0;
      t_unit  <= 32'd65536;
      law     <= '0;
      t_floor <= '0;
      e_scale <= 24'd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_STARS:    n_stars <= cfg_data[NUM_W-1:0];
          CFG_TEMP0:        t_unit  <= cfg_data;
          CFG_TEMPLAW:      law     <= cfg_data[LAW_W-1:0];
          CFG_TEMPMIN:      t_floor <= cfg_data;
          CFG_ENERGY_SCALE: e_scale <= cfg_data[ESC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_func) begin
          heat_q.push_back(nearest_heat(in_pos_x, in_pos_y, in_pos_z));
        end else begin
          star_px[in_star_slot] <= in_pos_x;
          star_py[in_star_slot] <= in_pos_y;
          star_pz[in_star_slot] <= in_pos_z;
        end
      end
      if (out_valid && out_ready) begin
        if (heat_q.size() == 0) begin
          $display("%0t unexpected result item", $realtime);
          errors++;
        end else begin
          w = heat_q.pop_front();
          if (out_temperature !== w.temp) report("temperature", out_temperature, w.temp);
          if (out_specific_energy !== w.energy)
            report("specific_energy", out_specific_energy, w.energy);
          if (out_nearest_dist_sq !== w.d2)
            report("nearest_dist_sq", out_nearest_dist_sq, w.d2);
          if (out_no_star !== w.none) report("no_star", out_no_star, w.none);
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives loads, queries and register writes into the nearest-star block with
// random gaps and result stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import nsplt_pkg::*;;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_func = 1'b0;
  logic [SLOT_W-1:0]     in_star_slot = '0;
  logic [FIELD_W-1:0]    in_pos_x = '0;
  logic [FIELD_W-1:0]    in_pos_y = '0;
  logic [FIELD_W-1:0]    in_pos_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TEMP_W-1:0]     out_temperature;
  logic [TEMP_W-1:0]     out_specific_energy;
  logic [D2_W-1:0]       out_nearest_dist_sq;
  logic                  out_no_star;

  int errors;
  int pending;

  // calm = no gaps and no stalls for a stretch
  bit calm = 1'b0;
  int stall_left = 0;

  // mirror of the star table, used to aim queries near stars
  logic [FIELD_W-1:0] sx [16];
  logic [FIELD_W-1:0] sy [16];
  logic [FIELD_W-1:0] sz [16];

  always #6 clk = ~clk;

  nearest_star_power_law_temperature u_dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_func, .in_star_slot, .in_pos_x, .in_pos_y, .in_pos_z,
    .out_valid, .out_ready, .out_temperature, .out_specific_energy,
    .out_nearest_dist_sq, .out_no_star
  );

  nsplt_checker u_chk (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_func, .in_star_slot, .in_pos_x, .in_pos_y, .in_pos_z,
    .out_valid, .out_ready, .out_temperature, .out_specific_energy,
    .out_nearest_dist_sq, .out_no_star,
    .errors, .pending
  );

  // result side: a fresh stall draw after every accepted result item
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      draw = calm ? 0 : $urandom_range(0, 15);
      stall_left <= draw;
      out_ready <= (draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one item; valid stays high afterwards until the next call or the end
  task automatic send_item(input logic f, input logic [SLOT_W-1:0] slot,
                           input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                           input logic [FIELD_W-1:0] z);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_star_slot <= slot;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    if (!f) begin
      sx[slot] = x;
      sy[slot] = y;
      sz[slot] = z;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // every result in, then room for a trailing load or query still in flight
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_query();
    int k;
    logic [FIELD_W-1:0] dx;
    logic [FIELD_W-1:0] dy;
    logic [FIELD_W-1:0] dz;
    k = $urandom_range(0, 15);
    dx = FIELD_W'($urandom_range(0, 8192)) - FIELD_W'(4096);
    dy = FIELD_W'($urandom_range(0, 8192)) - FIELD_W'(4096);
    dz = FIELD_W'($urandom_range(0, 8192)) - FIELD_W'(4096);
    case ($urandom_range(0, 9))
      0, 1:    send_item(1'b1, '0, sx[k], sy[k], sz[k]);             // on a star
      2, 3, 4, 5, 6:
               send_item(1'b1, '0, sx[k] + dx, sy[k] + dy, sz[k] + dz);
      default: send_item(1'b1, '0, FIELD_W'($urandom), FIELD_W'($urandom),
                         FIELD_W'($urandom));
    endcase
  endtask

  initial begin
    logic [FIELD_W-1:0] pmax;
    logic [FIELD_W-1:0] pmin;
    pmax = {1'b0, {(FIELD_W-1){1'b1}}};
    pmin = {1'b1, {(FIELD_W-1){1'b0}}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table query, then fill every slot
    send_item(1'b1, '0, pmax, pmin, '0);
    send_item(1'b0, 4'd0, '0, '0, '0);
    send_item(1'b0, 4'd1, pmax, pmax, pmax);
    send_item(1'b0, 4'd2, pmin, pmin, pmin);
    for (int s = 3; s < 16; s++)
      send_item(1'b0, SLOT_W'(s), FIELD_W'($urandom), FIELD_W'($urandom),
                FIELD_W'($urandom));
    drain();
    write_reg(CFG_NUM_STARS, 32'd31);                 // above table size
    send_item(1'b1, '0, '0, '0, '0);                  // zero distance, law 0
    send_item(1'b1, '0, pmin, pmin, pmin);
    send_item(1'b1, '0, pmax, pmin, pmax);            // far from every star
    send_item(1'b1, '0, 24'h000001, '0, '0);          // smallest nonzero distance

    // phases of register settings, extremes first
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_NUM_STARS, 32'd16);
          write_reg(CFG_TEMP0, 32'hFFFF_FFFF);
          write_reg(CFG_TEMPLAW, 32'h0000_7FFF);
          write_reg(CFG_TEMPMIN, 32'd0);
          write_reg(CFG_ENERGY_SCALE, 32'h00FF_FFFF);
        end
        1: begin
          write_reg(CFG_NUM_STARS, 32'd1);
          write_reg(CFG_TEMP0, 32'd0);
          write_reg(CFG_TEMPLAW, 32'h0000_8000);
          write_reg(CFG_TEMPMIN, 32'hFFFF_FFFF);
          write_reg(CFG_ENERGY_SCALE, 32'd0);
        end
        2: begin
          write_reg(CFG_NUM_STARS, 32'd0);
          write_reg(CFG_TEMPMIN, 32'h0123_4567);
          write_reg(CFG_ENERGY_SCALE, 32'h0001_8000);
        end
        3: begin
          // mild power law, typical magnitudes
          write_reg(CFG_NUM_STARS, 32'd8);
          write_reg(CFG_TEMP0, 32'h0064_0000);
          write_reg(CFG_TEMPLAW, 32'h0000_0800);
          write_reg(CFG_TEMPMIN, 32'h000A_0000);
          write_reg(CFG_ENERGY_SCALE, 32'h0001_0000);
        end
        4: begin
          write_reg(CFG_NUM_STARS, 32'd16);
          write_reg(CFG_TEMPLAW, 32'h0000_F800);
          write_reg(CFG_TEMPMIN, 32'd0);
        end
        default: begin
          write_reg(CFG_NUM_STARS, $urandom_range(0, 31));
          write_reg(CFG_TEMP0, $urandom);
          write_reg(CFG_TEMPLAW, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8192)
                    - 4096);
          write_reg(CFG_TEMPMIN, $urandom_range(0, 1) ? 32'd0 : $urandom >> 8);
          write_reg(CFG_ENERGY_SCALE, $urandom);
        end
      endcase
      calm = (ph % 3 == 2);
      for (int i = 0; i < 190; i++) begin
        if (ph == 5 && i == 95) begin
          // sender holds off until every expected result is back
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        if ($urandom_range(0, 4) == 0)
          send_item(1'b0, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                    FIELD_W'($urandom));
        else
          random_query();
      end
    end
    calm = 1'b0;
    drain();

    if (errors == 0 && pending == 0) begin
      $display("PASS nearest_star_power_law_temperature");
    end else begin
      $display("FAIL nearest_star_power_law_temperature");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL nearest_star_power_law_temperature");
    $finish;
  end

endmodule
